FILE: design/lbs_pkg.sv
// ----------------------------------------------------------------------------
// Linear blend skinning package
// Shared constants, types and a saturation helper for the skinning engine.
// ----------------------------------------------------------------------------
package lbs_pkg;

   localparam int ELEMS    = 12;
   localparam int SLOTS    = 4;
   localparam int ID_W     = 6;
   localparam int WEIGHT_W = 16;

   localparam logic KIND_TABLE  = 1'b0;
   localparam logic KIND_VERTEX = 1'b1;

   typedef logic signed [31:0] word_type;
   typedef logic signed [48:0] wprod_type;
   typedef logic signed [47:0] cprod_type;

   function automatic word_type sat51(input logic signed [50:0] v);
      word_type r;
      if (v > 51'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -51'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

FILE: design/linear_blend_skinning.sv
// ----------------------------------------------------------------------------
// Linear blend skinning engine
// Four-bone vertex skinning with a Q16.16 bone matrix store.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): kind 0 writes one matrix element of one bone,
//   kind 1 skins one vertex. Result channel (rsp_*) returns one deformed
//   position and normal per vertex request; table writes give no result.
//   Throughput is one request per cycle while not clearing or held. A vertex
//   result passes registered stages after its request is accepted: memory
//   read, weight products, blend and saturate, coordinate products, row sums
//   and saturate. The store is one memory per slot and element, so four
//   bones are read per cycle while the pipeline is not held; a write lands
//   in all four copies at its accept edge and is seen by every later vertex.
//   After reset a clearing pass zeroes the store, one bone per cycle, for
//   all MAX_BONES bones; req_ready stays low during it.
//   When rsp_ready is low with a result held, the whole pipeline holds and
//   req_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module linear_blend_skinning #(
   parameter int MAX_BONES = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_kind,
   input  lbs_pkg::word_type       req_pos_x,
   input  lbs_pkg::word_type       req_pos_y,
   input  lbs_pkg::word_type       req_pos_z,
   input  lbs_pkg::word_type       req_nrm_x,
   input  lbs_pkg::word_type       req_nrm_y,
   input  lbs_pkg::word_type       req_nrm_z,
   input  logic [23:0]             req_bone_ids,
   input  logic [63:0]             req_weights,
   input  logic [5:0]              req_table_bone,
   input  logic [3:0]              req_table_element,
   input  lbs_pkg::word_type       req_table_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output lbs_pkg::word_type       rsp_out_pos_x,
   output lbs_pkg::word_type       rsp_out_pos_y,
   output lbs_pkg::word_type       rsp_out_pos_z,
   output lbs_pkg::word_type       rsp_out_nrm_x,
   output lbs_pkg::word_type       rsp_out_nrm_y,
   output lbs_pkg::word_type       rsp_out_nrm_z
);
   import lbs_pkg::*;

   localparam int AW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
   localparam int IW = (AW > ID_W) ? AW : ID_W;

   logic                   en;
   logic                   accept;
   logic                   clr_ff;
   logic [AW-1:0]          clr_cnt_ff;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [3:0]             wr_elem;
   word_type               wr_data;
   logic [IW-1:0]          id_ext [SLOTS];
   logic [AW-1:0]          rd_addr [SLOTS];
   logic                   ok_in [SLOTS];
   logic [IW-1:0]          tb_ext;

   // stage 1
   logic                   v1_ff;
   word_type               rd_ff [SLOTS][ELEMS];
   logic [WEIGHT_W-1:0]    w1_ff [SLOTS];
   logic                   ok1_ff [SLOTS];
   word_type               pos1_ff [3];
   word_type               nrm1_ff [3];
   // stage 2
   logic                   v2_ff;
   wprod_type              prod_in [ELEMS][SLOTS];
   wprod_type              prod2_ff [ELEMS][SLOTS];
   word_type               pos2_ff [3];
   word_type               nrm2_ff [3];
   // stage 3
   logic                   v3_ff;
   word_type               mat_in [ELEMS];
   word_type               mat3_ff [ELEMS];
   word_type               pos3_ff [3];
   word_type               nrm3_ff [3];
   // stage 4
   logic                   v4_ff;
   cprod_type              pp_in [3][3];
   cprod_type              np_in [3][3];
   cprod_type              pp4_ff [3][3];
   cprod_type              np4_ff [3][3];
   word_type               t4_ff [3];
   // stage 5
   logic                   v5_ff;
   word_type               po_in [3];
   word_type               no_in [3];
   word_type               po5_ff [3];
   word_type               no5_ff [3];

   assign en        = !v5_ff || rsp_ready;
   assign req_ready = en && !clr_ff;
   assign accept    = req_valid && req_ready;

   // clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
      end else if (clr_ff) begin
         clr_cnt_ff <= clr_cnt_ff + AW'(1);
         if (clr_cnt_ff == AW'(MAX_BONES - 1)) begin
            clr_ff <= 1'b0;
         end
      end
   end

   assign tb_ext  = IW'(req_table_bone);
   assign wr_en   = clr_ff || (accept && req_kind == KIND_TABLE
                    && 32'(tb_ext) < MAX_BONES && req_table_element < 4'(ELEMS));
   assign wr_addr = clr_ff ? clr_cnt_ff : tb_ext[AW-1:0];
   assign wr_elem = req_table_element;
   assign wr_data = clr_ff ? '0 : req_table_value;

   always_comb begin
      for (int s = 0; s < SLOTS; s++) begin
         id_ext[s]  = IW'(req_bone_ids[s*ID_W +: ID_W]);
         rd_addr[s] = id_ext[s][AW-1:0];
         ok_in[s]   = 32'(id_ext[s]) < MAX_BONES;
      end
   end

   for (genvar gs = 0; gs < SLOTS; gs++) begin : g_slot
      for (genvar ge = 0; ge < ELEMS; ge++) begin : g_elem
         word_type mem [MAX_BONES];
         always_ff @(posedge clock) begin
            if (wr_en && (clr_ff || wr_elem == 4'(ge))) begin
               mem[wr_addr] <= wr_data;
            end
            if (en) begin
               rd_ff[gs][ge] <= mem[rd_addr[gs]];
            end
         end
      end
   end

   always_comb begin
      for (int e = 0; e < ELEMS; e++) begin
         for (int s = 0; s < SLOTS; s++) begin
            if (ok1_ff[s]) begin
               prod_in[e][s] = wprod_type'(rd_ff[s][e])
                             * wprod_type'({1'b0, w1_ff[s]});
            end else begin
               prod_in[e][s] = '0;
            end
         end
      end
   end

   always_comb begin
      logic signed [50:0] acc;
      for (int e = 0; e < ELEMS; e++) begin
         acc = 51'(prod2_ff[e][0]) + 51'(prod2_ff[e][1])
             + 51'(prod2_ff[e][2]) + 51'(prod2_ff[e][3]);
         mat_in[e] = sat51(acc >>> 15);
      end
   end

   always_comb begin
      logic signed [63:0] p;
      logic signed [63:0] n;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            p = mat3_ff[r*4 + c] * pos3_ff[c];
            n = mat3_ff[r*4 + c] * nrm3_ff[c];
            pp_in[r][c] = cprod_type'(p >>> 16);
            np_in[r][c] = cprod_type'(n >>> 16);
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         po_in[r] = sat51(51'(pp4_ff[r][0]) + 51'(pp4_ff[r][1])
                        + 51'(pp4_ff[r][2]) + 51'(t4_ff[r]));
         no_in[r] = sat51(51'(np4_ff[r][0]) + 51'(np4_ff[r][1])
                        + 51'(np4_ff[r][2]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= accept && req_kind == KIND_VERTEX;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < SLOTS; s++) begin
            w1_ff[s]  <= req_weights[s*WEIGHT_W +: WEIGHT_W];
            ok1_ff[s] <= ok_in[s];
         end
         pos1_ff[0] <= req_pos_x;
         pos1_ff[1] <= req_pos_y;
         pos1_ff[2] <= req_pos_z;
         nrm1_ff[0] <= req_nrm_x;
         nrm1_ff[1] <= req_nrm_y;
         nrm1_ff[2] <= req_nrm_z;
         prod2_ff   <= prod_in;
         pos2_ff    <= pos1_ff;
         nrm2_ff    <= nrm1_ff;
         mat3_ff    <= mat_in;
         pos3_ff    <= pos2_ff;
         nrm3_ff    <= nrm2_ff;
         pp4_ff     <= pp_in;
         np4_ff     <= np_in;
         for (int r = 0; r < 3; r++) begin
            t4_ff[r] <= mat3_ff[r*4 + 3];
         end
         po5_ff     <= po_in;
         no5_ff     <= no_in;
      end
   end

   assign rsp_valid     = v5_ff;
   assign rsp_out_pos_x = po5_ff[0];
   assign rsp_out_pos_y = po5_ff[1];
   assign rsp_out_pos_z = po5_ff[2];
   assign rsp_out_nrm_x = no5_ff[0];
   assign rsp_out_nrm_y = no5_ff[1];
   assign rsp_out_nrm_z = no5_ff[2];

endmodule
